// ===== design/bssim_pkg.sv =====
// ----------------------------------------------------------------------------
// bssim_pkg: shared types and constants of the block ssim metric unit
// Beat types of both queue ports, the record passed from the front to the
// back, divider control and the configuration register map.
// ----------------------------------------------------------------------------
package bssim_pkg;

	// default sizing, handed down from the top level
	localparam int PIXEL_BITS_DEF     = 16;
	localparam int MAX_BLOCK_SIDE_DEF = 16;
	localparam int COUNT_BITS_DEF     = 24;

	// fixed field and accumulator widths
	localparam int PIX_W     = 16;
	localparam int SUM_W     = 24;
	localparam int SQ_W      = 40;
	localparam int PIX_CNT_W = 9;
	localparam int SIDE_W    = 5;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 2;
	localparam int MEAN_W    = 32;
	localparam int SHOWN_W   = 24;
	localparam int DIV_W     = 64;
	localparam int STEP_W    = 7;
	localparam int Q_DEPTH   = 2;

	// register map
	localparam logic [IDX_W-1:0] REG_BLOCK_SIDE = 2'd0;
	localparam logic [IDX_W-1:0] REG_C1         = 2'd1;
	localparam logic [IDX_W-1:0] REG_C2         = 2'd2;

	// register reset values
	localparam logic [SIDE_W-1:0] BLOCK_SIDE_RST = 5'd8;
	localparam logic [CFG_W-1:0]  C1_RST         = 16'd1665;
	localparam logic [CFG_W-1:0]  C2_RST         = 16'd14982;

	// q1.30 fraction
	localparam int                RATIO_STEPS = 30;
	localparam logic [30:0]       Q30_ONE     = 31'h4000_0000;

	typedef struct packed {
		logic [PIX_W-1:0] ref_pixel;
		logic [PIX_W-1:0] test_pixel;
		logic             image_end;
	} in_item_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] ssim_mean;
		logic [SHOWN_W-1:0]       blocks_seen;
		logic                     no_blocks;
	} out_item_t;

	// one block or image event from the front
	typedef struct packed {
		logic [SUM_W-1:0]     sum_ref;
		logic [SUM_W-1:0]     sum_test;
		logic [SQ_W-1:0]      sum_ref_sq;
		logic [SQ_W-1:0]      sum_test_sq;
		logic [SQ_W-1:0]      sum_cross;
		logic [PIX_CNT_W-1:0] pixels;
		logic [CFG_W-1:0]     c1;
		logic [CFG_W-1:0]     c2;
		logic                 is_block;
		logic                 is_end;
	} rec_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  dividend;
		logic [DIV_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== design/bssim_front.sv =====
// ----------------------------------------------------------------------------
// bssim_front: pixel accumulator
// Takes one pixel pair per cycle unless the queue is full, keeps the block
// sums, and queues a record when a block completes or the image ends.
// ----------------------------------------------------------------------------
module bssim_front #(
	parameter int PIXEL_BITS     = bssim_pkg::PIXEL_BITS_DEF,
	parameter int MAX_BLOCK_SIDE = bssim_pkg::MAX_BLOCK_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  bssim_pkg::in_item_t           in_item,
	input  logic [bssim_pkg::SIDE_W-1:0]  block_side,
	input  logic [bssim_pkg::CFG_W-1:0]   c1,
	input  logic [bssim_pkg::CFG_W-1:0]   c2,
	output logic                          rec_push,
	output bssim_pkg::rec_t               rec,
	input  logic                          rec_full
);
	import bssim_pkg::*;

	localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(MAX_BLOCK_SIDE);

	logic [SUM_W-1:0]     sum_ref_q, sum_test_q;
	logic [SQ_W-1:0]      sum_ref_sq_q, sum_test_sq_q, sum_cross_q;
	logic [PIX_CNT_W-1:0] pix_q;

	logic [PIX_W-1:0]     x, y;
	logic [SIDE_W-1:0]    side;
	logic [2*SIDE_W-1:0]  need;
	logic                 accept, blk_done, event_hit;
	rec_t                 nxt;

	// a beat is refused only while the queue is full
	assign full   = rec_full;
	assign accept = push && !rec_full;

	// clamp the side into the legal range
	always_comb begin
		if (block_side == '0) begin
			side = SIDE_W'(1);
		end else if (block_side > MAX_SIDE) begin
			side = MAX_SIDE;
		end else begin
			side = block_side;
		end
		need = side * side;
	end

	// next sums with this pixel folded in
	always_comb begin
		x = PIX_W'(in_item.ref_pixel[PIXEL_BITS-1:0]);
		y = PIX_W'(in_item.test_pixel[PIXEL_BITS-1:0]);
		nxt.sum_ref     = sum_ref_q + SUM_W'(x);
		nxt.sum_test    = sum_test_q + SUM_W'(y);
		nxt.sum_ref_sq  = sum_ref_sq_q + SQ_W'(32'(x) * 32'(x));
		nxt.sum_test_sq = sum_test_sq_q + SQ_W'(32'(y) * 32'(y));
		nxt.sum_cross   = sum_cross_q + SQ_W'(32'(x) * 32'(y));
		nxt.pixels      = pix_q + PIX_CNT_W'(1);
		nxt.c1          = c1;
		nxt.c2          = c2;
		blk_done        = (2*SIDE_W)'(nxt.pixels) >= need;
		nxt.is_block    = blk_done;
		nxt.is_end      = in_item.image_end;
		event_hit       = blk_done || in_item.image_end;
	end

	assign rec_push = accept && event_hit;
	assign rec      = nxt;

	// block sums, cleared after every event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_ref_q     <= '0;
			sum_test_q    <= '0;
			sum_ref_sq_q  <= '0;
			sum_test_sq_q <= '0;
			sum_cross_q   <= '0;
			pix_q         <= '0;
		end else if (accept) begin
			if (event_hit) begin
				sum_ref_q     <= '0;
				sum_test_q    <= '0;
				sum_ref_sq_q  <= '0;
				sum_test_sq_q <= '0;
				sum_cross_q   <= '0;
				pix_q         <= '0;
			end else begin
				sum_ref_q     <= nxt.sum_ref;
				sum_test_q    <= nxt.sum_test;
				sum_ref_sq_q  <= nxt.sum_ref_sq;
				sum_test_sq_q <= nxt.sum_test_sq;
				sum_cross_q   <= nxt.sum_cross;
				pix_q         <= nxt.pixels;
			end
		end
	end

endmodule

// ===== design/bssim_fifo.sv =====
// ----------------------------------------------------------------------------
// bssim_fifo: event queue
// Short queue of block records between the accumulator and the back end.
// ----------------------------------------------------------------------------
module bssim_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bssim_pkg::rec_t wdata,
	output logic            full,
	input  logic            pop,
	output bssim_pkg::rec_t rdata,
	output logic            empty
);
	import bssim_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	rec_t             mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CNT_W'(Q_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/bssim_divider.sv =====
// ----------------------------------------------------------------------------
// bssim_divider: serial restoring divider
// One quotient bit per cycle. The remainder starts at a given value and the
// dividend bits are shifted in from the top, so the same unit forms q1.30
// fractions and integer quotients.
// ----------------------------------------------------------------------------
module bssim_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  bssim_pkg::div_req_t req,
	output bssim_pkg::div_rsp_t rsp
);
	import bssim_pkg::*;

	logic [DIV_W-1:0]  r_q, d_q, q_q, div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              active_q, done_q;
	logic [DIV_W-1:0]  rs, r_next;
	logic              qbit;

	// one restoring step
	always_comb begin
		rs     = {r_q[DIV_W-2:0], d_q[DIV_W-1]};
		qbit   = rs >= div_q;
		r_next = qbit ? rs - div_q : rs;
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = q_q;

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q   <= req.rem_init;
			d_q   <= req.dividend;
			div_q <= req.divisor;
			q_q   <= '0;
		end else if (active_q) begin
			r_q <= r_next;
			d_q <= {d_q[DIV_W-2:0], 1'b0};
			q_q <= {q_q[DIV_W-2:0], qbit};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q    <= req.steps;
				active_q <= 1'b1;
			end else if (active_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/bssim_back.sv =====
// ----------------------------------------------------------------------------
// bssim_back: ssim term and mean
// Takes block records from the queue, forms the per-block ssim term with a
// shared multiplier and the serial divider, keeps the running total and
// block count, and produces the mean at image end.
// ----------------------------------------------------------------------------
module bssim_back #(
	parameter int COUNT_BITS = bssim_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  bssim_pkg::rec_t      q_data,
	output logic                 q_pop,
	output bssim_pkg::out_item_t out_item,
	output logic                 empty,
	input  logic                 pop
);
	import bssim_pkg::*;

	localparam int TOT_W = COUNT_BITS + 32;
	localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_MUL    = 13'b0000000000010,
		S_FORM1  = 13'b0000000000100,
		S_FORM2  = 13'b0000000001000,
		S_LUM    = 13'b0000000010000,
		S_LUM_W  = 13'b0000000100000,
		S_CS     = 13'b0000001000000,
		S_CS_W   = 13'b0000010000000,
		S_PROD   = 13'b0000100000000,
		S_ACC    = 13'b0001000000000,
		S_END    = 13'b0010000000000,
		S_MEAN_W = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	state_t state_q;
	rec_t   rec_q;
	logic [3:0] mstep_q;

	// products
	logic [63:0] kk_q, sxx_q, syy_q, sxy_q, kxx_q, kyy_q, kxy_q, c1kk_q, c2kk_q;
	logic signed [63:0] vx_q, vy_q, cv_q;
	logic [63:0] a_q, d1_q, bmag_q, d2_q;
	logic        bneg_q, tneg_q;
	logic [30:0] lum_q, cs_q;
	logic [61:0] prod_q;

	logic signed [TOT_W-1:0] total_q;
	logic [COUNT_BITS-1:0]   count_q;

	logic                 out_valid_q;
	out_item_t            out_q;
	out_item_t            res_q;

	logic [39:0]          mul_a;
	logic [23:0]          mul_b;
	logic [63:0]          mul_p;
	logic signed [63:0]   vx_raw, vy_raw, b_s;
	logic signed [31:0]   term_s;
	logic [TOT_W-1:0]     tot_mag;
	logic [63:0]          cnt64;
	logic [31:0]          mean_mag;
	logic                 out_free;
	div_req_t             dreq;
	div_rsp_t             drsp;

	bssim_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign out_free = !out_valid_q || pop;
	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign empty    = !out_valid_q;
	assign out_item = out_q;

	// shared multiplier operand select
	always_comb begin
		case (mstep_q)
			4'd0: begin mul_a = 40'(rec_q.pixels);   mul_b = 24'(rec_q.pixels); end
			4'd1: begin mul_a = 40'(rec_q.sum_ref);  mul_b = rec_q.sum_ref;     end
			4'd2: begin mul_a = 40'(rec_q.sum_test); mul_b = rec_q.sum_test;    end
			4'd3: begin mul_a = 40'(rec_q.sum_ref);  mul_b = rec_q.sum_test;    end
			4'd4: begin mul_a = rec_q.sum_ref_sq;    mul_b = 24'(rec_q.pixels); end
			4'd5: begin mul_a = rec_q.sum_test_sq;   mul_b = 24'(rec_q.pixels); end
			4'd6: begin mul_a = rec_q.sum_cross;     mul_b = 24'(rec_q.pixels); end
			4'd7: begin mul_a = 40'(rec_q.c1);       mul_b = kk_q[23:0];        end
			4'd8: begin mul_a = 40'(rec_q.c2);       mul_b = kk_q[23:0];        end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	// raw variances, contrast numerator, signed block term and mean operands
	always_comb begin
		vx_raw = $signed(kxx_q) - $signed(sxx_q);
		vy_raw = $signed(kyy_q) - $signed(syy_q);
		b_s    = (cv_q <<< 9) + $signed(c2kk_q);
		term_s = tneg_q ? -$signed(prod_q[61:30]) : $signed(prod_q[61:30]);
		tot_mag = total_q[TOT_W-1] ? $unsigned(-total_q) : $unsigned(total_q);
		cnt64  = 64'(count_q);
		mean_mag = drsp.quotient[31:0];
	end

	// divider requests
	always_comb begin
		dreq = '0;
		case (state_q)
			S_LUM: begin
				dreq.start    = (d1_q != '0) && (a_q < d1_q);
				dreq.rem_init = a_q;
				dreq.divisor  = d1_q;
				dreq.steps    = STEP_W'(RATIO_STEPS);
			end
			S_CS: begin
				dreq.start    = (d2_q != '0) && (bmag_q < d2_q);
				dreq.rem_init = bmag_q;
				dreq.divisor  = d2_q;
				dreq.steps    = STEP_W'(RATIO_STEPS);
			end
			S_END: begin
				dreq.start    = count_q != '0;
				dreq.dividend = 64'(tot_mag);
				dreq.divisor  = cnt64;
				dreq.steps    = STEP_W'(DIV_W);
			end
			default: dreq = '0;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					rec_q <= q_data;
				end
			end
			S_MUL: begin
				case (mstep_q)
					4'd0: kk_q   <= mul_p;
					4'd1: sxx_q  <= mul_p;
					4'd2: syy_q  <= mul_p;
					4'd3: sxy_q  <= mul_p;
					4'd4: kxx_q  <= mul_p;
					4'd5: kyy_q  <= mul_p;
					4'd6: kxy_q  <= mul_p;
					4'd7: c1kk_q <= mul_p;
					4'd8: c2kk_q <= mul_p;
					default: ;
				endcase
			end
			S_FORM1: begin
				vx_q <= (vx_raw < 0) ? '0 : vx_raw;
				vy_q <= (vy_raw < 0) ? '0 : vy_raw;
				cv_q <= $signed(kxy_q) - $signed(sxy_q);
			end
			S_FORM2: begin
				a_q    <= (sxy_q << 9) + c1kk_q;
				d1_q   <= ((sxx_q + syy_q) << 8) + c1kk_q;
				d2_q   <= ($unsigned(vx_q + vy_q) << 8) + c2kk_q;
				bneg_q <= b_s < 0;
				bmag_q <= (b_s < 0) ? $unsigned(-b_s) : $unsigned(b_s);
			end
			S_LUM: begin
				if (!dreq.start) begin
					lum_q <= Q30_ONE;
				end
			end
			S_LUM_W: begin
				if (drsp.done) begin
					lum_q <= drsp.quotient[30:0];
				end
			end
			S_CS: begin
				if (!dreq.start) begin
					cs_q <= Q30_ONE;
				end
			end
			S_CS_W: begin
				if (drsp.done) begin
					cs_q <= drsp.quotient[30:0];
				end
			end
			S_PROD: begin
				prod_q <= 62'(lum_q) * 62'(cs_q);
				tneg_q <= bneg_q;
			end
			S_END: begin
				if (count_q == '0) begin
					res_q.ssim_mean   <= '0;
					res_q.blocks_seen <= '0;
					res_q.no_blocks   <= 1'b1;
				end
			end
			S_MEAN_W: begin
				if (drsp.done) begin
					res_q.ssim_mean   <= total_q[TOT_W-1] ? -$signed(mean_mag)
					                                      : $signed(mean_mag);
					res_q.blocks_seen <= (cnt64 > 64'(SHOWN_W'('1))) ? SHOWN_W'('1)
					                                                 : cnt64[SHOWN_W-1:0];
					res_q.no_blocks   <= 1'b0;
				end
			end
			// result beat moves to the output only once the old one is gone
			S_OUT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer, running total and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mstep_q     <= '0;
			total_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						mstep_q <= '0;
						state_q <= q_data.is_block ? S_MUL : S_END;
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q == 4'd8) begin
						state_q <= S_FORM1;
					end
				end
				S_FORM1: state_q <= S_FORM2;
				S_FORM2: state_q <= S_LUM;
				S_LUM:   state_q <= dreq.start ? S_LUM_W : S_CS;
				S_LUM_W: begin
					if (drsp.done) begin
						state_q <= S_CS;
					end
				end
				S_CS:    state_q <= dreq.start ? S_CS_W : S_PROD;
				S_CS_W: begin
					if (drsp.done) begin
						state_q <= S_PROD;
					end
				end
				S_PROD:  state_q <= S_ACC;
				S_ACC: begin
					if (count_q < CAP) begin
						total_q <= total_q + TOT_W'(term_s);
						count_q <= count_q + COUNT_BITS'(1);
					end
					state_q <= rec_q.is_end ? S_END : S_IDLE;
				end
				S_END:   state_q <= (count_q == '0) ? S_OUT : S_MEAN_W;
				S_MEAN_W: begin
					if (drsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						total_q     <= '0;
						count_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/block_ssim_metric_unit.sv =====
// ----------------------------------------------------------------------------
// block_ssim_metric_unit: block ssim metric
// Mean structural similarity over square blocks of a pixel pair stream.
// ----------------------------------------------------------------------------
// Pixel pairs enter at one beat per cycle while the event queue has room.
// Each complete block then passes through the back end: its products on the
// shared multiplier, the variance and ratio terms, and one serial divider
// pass for each of the two ratios that is not clamped to 1.0. The image end
// adds the 64-step mean division. A two-entry queue holds block records, so
// blocks that take the front at least as long as the back end spends on one
// block stream without stalls; smaller blocks hold full high until the back
// end catches up. The result beat sits in an output register and the unit
// keeps taking pixels while it waits to be popped.
// ----------------------------------------------------------------------------
module block_ssim_metric_unit #(
	parameter int PIXEL_BITS     = bssim_pkg::PIXEL_BITS_DEF,
	parameter int MAX_BLOCK_SIDE = bssim_pkg::MAX_BLOCK_SIDE_DEF,
	parameter int COUNT_BITS     = bssim_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  bssim_pkg::in_item_t          in_item,
	output logic                         empty,
	input  logic                         pop,
	output bssim_pkg::out_item_t         out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bssim_pkg::IDX_W-1:0]  cfg_index,
	input  logic [bssim_pkg::CFG_W-1:0]  cfg_data
);
	import bssim_pkg::*;

	logic [SIDE_W-1:0] block_side_q;
	logic [CFG_W-1:0]  c1_q, c2_q;
	logic              rec_push, rec_full, q_empty, q_pop;
	rec_t              rec_w, rec_r;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_side_q <= BLOCK_SIDE_RST;
			c1_q         <= C1_RST;
			c2_q         <= C2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLOCK_SIDE: block_side_q <= cfg_data[SIDE_W-1:0];
				REG_C1:         c1_q         <= cfg_data;
				REG_C2:         c2_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	bssim_front #(
		.PIXEL_BITS     (PIXEL_BITS),
		.MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.block_side (block_side_q),
		.c1         (c1_q),
		.c2         (c2_q),
		.rec_push   (rec_push),
		.rec        (rec_w),
		.rec_full   (rec_full)
	);

	bssim_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_w),
		.full   (rec_full),
		.pop    (q_pop),
		.rdata  (rec_r),
		.empty  (q_empty)
	);

	bssim_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (rec_r),
		.q_pop    (q_pop),
		.out_item (out_item),
		.empty    (empty),
		.pop      (pop)
	);

endmodule
